/* rtl/bfd_pkg.sv */
// Shared types, codes, constants and helper functions of the buoyancy/drag core.
`default_nettype none
package bfd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAG      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_EXT  = 4'd7;

  // Reset values
  localparam logic [30:0] DENSITY_RST = 31'd65536;
  localparam logic [30:0] GRAVITY_RST = 31'd642253;

  // Shape codes
  localparam logic [1:0] SHAPE_SPHERE = 2'd0;
  localparam logic [1:0] SHAPE_BOX    = 2'd1;

  // Volume class of a body
  localparam logic [1:0] VC_ZERO = 2'd0;  // sphere fully above the surface
  localparam logic [1:0] VC_FULL = 2'd1;  // sphere fully submerged
  localparam logic [1:0] VC_PART = 2'd2;  // spherical cap
  localparam logic [1:0] VC_BOX  = 2'd3;

  localparam logic [17:0] PI_Q16    = 18'd205887;
  localparam logic [17:0] THREE_Q16 = 18'd196608;
  localparam logic [17:0] ONE_Q16   = 18'd65536;
  localparam logic [46:0] FORCE_MAX = 47'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic       apply;
    logic       vneg;
    logic [1:0] cls;
    logic       rzero;
    logic       rone;
  } ctl_t;

  typedef struct packed {
    logic        qbit;
    logic [31:0] rem;
  } divs_t;

  typedef struct packed {
    logic [3:0] q;
    logic [1:0] rem;
  } div3_t;

  // |d| <= lim on one axis
  function automatic logic in_range(logic signed [32:0] d, logic [30:0] lim);
    logic [32:0] mag;
    mag = d[32] ? 33'(-d) : 33'(d);
    return mag <= {2'b00, lim};
  endfunction

  // One restoring division step, rem < b on entry
  function automatic divs_t div_step(logic [31:0] rem, logic [31:0] b);
    logic [32:0] rem2;
    divs_t res;
    rem2 = {rem, 1'b0};
    if (rem2 >= {1'b0, b}) begin
      res.qbit = 1'b1;
      res.rem  = 32'(rem2 - {1'b0, b});
    end else begin
      res.qbit = 1'b0;
      res.rem  = rem2[31:0];
    end
    return res;
  endfunction

  // One nibble of a divide by three; reciprocal 171/512 is exact below 48
  function automatic div3_t div3_nib(logic [1:0] rem, logic [3:0] nib);
    logic [5:0]  cur;
    logic [13:0] prod;
    logic [5:0]  back;
    div3_t res;
    cur     = {rem, nib};
    prod    = 14'(cur) * 14'd171;
    res.q   = prod[12:9];
    back    = 6'({res.q, 1'b0}) + 6'(res.q);
    res.rem = 2'(cur - back);
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/bfd_in_if.sv */
// Body request channel: valid/ready handshake with the body fields.
`default_nettype none
interface bfd_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  shape_kind;
  logic               is_static;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_y;
  logic        [30:0] sphere_radius;
  logic        [30:0] half_x;
  logic        [30:0] half_y;
  logic        [30:0] half_z;

  modport source (output valid, shape_kind, is_static, pos_x, pos_y, pos_z, vel_y,
                  sphere_radius, half_x, half_y, half_z, input ready);
  modport sink (input valid, shape_kind, is_static, pos_x, pos_y, pos_z, vel_y,
                sphere_radius, half_x, half_y, half_z, output ready);
endinterface
`default_nettype wire

/* rtl/bfd_out_if.sv */
// Force result channel: valid/ready handshake with the force fields.
`default_nettype none
interface bfd_out_if;
  logic               valid;
  logic               ready;
  logic        [46:0] buoyant_force;
  logic signed [47:0] damping_force;
  logic               force_applied;
  logic               saturated;

  modport source (output valid, buoyant_force, damping_force, force_applied, saturated,
                  input ready);
  modport sink (input valid, buoyant_force, damping_force, force_applied, saturated,
                output ready);
endinterface
`default_nettype wire

/* rtl/buoyancy_and_fluid_drag_force_core.sv */
// Top level: pipelined buoyancy and vertical drag force for one body per request.
`default_nettype none
// One body request is taken per clock and its force result passes through ten
// compute stages and the output register; the whole pipe advances together
// and holds while the output register is full and not taken, so throughput is one
// request per cycle. The body is tested against the cubic beaker, classed (sphere
// cap, full sphere, empty, box slab), and its submerged volume built from two
// chained Q16.16 multiplies, a divide by three and a multiply by pi, all but the
// first multiply split over two stages each. The submerged ratio comes from a
// 17-bit restoring divider spread over three stages, then the cap polynomial.
// Buoyant force = (density*gravity)*volume, clipped at 2^47-1 with saturated set.
// Configuration writes take effect at once and are meant only while the pipe is
// empty; density*gravity is re-registered every cycle from the registers.
module buoyancy_and_fluid_drag_force_core
  import bfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  bfd_in_if.sink                    in_ch,
  bfd_out_if.source                 out_ch
);

  // ---------------- configuration registers ----------------
  logic signed [31:0] surf_r, bcx_r, bcy_r, bcz_r;
  logic        [30:0] dens_r, drag_r, grav_r, bhalf_r;
  logic        [45:0] dg_r;
  logic        [61:0] dg_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_r  <= '0;
      dens_r  <= DENSITY_RST;
      drag_r  <= '0;
      grav_r  <= GRAVITY_RST;
      bcx_r   <= '0;
      bcy_r   <= '0;
      bcz_r   <= '0;
      bhalf_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SURFACE:  surf_r  <= cfg_wdata;
        REG_DENSITY:  dens_r  <= cfg_wdata[30:0];
        REG_DRAG:     drag_r  <= cfg_wdata[30:0];
        REG_GRAVITY:  grav_r  <= cfg_wdata[30:0];
        REG_CENTER_X: bcx_r   <= cfg_wdata;
        REG_CENTER_Y: bcy_r   <= cfg_wdata;
        REG_CENTER_Z: bcz_r   <= cfg_wdata;
        REG_HALF_EXT: bhalf_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign dg_full = 62'(dens_r) * 62'(grav_r);
  always_ff @(posedge clk) begin
    dg_r <= dg_full[61:16];
  end

  // ---------------- pipeline control ----------------
  logic       en;
  logic [9:0] vld_r;       // vld_r[k] is stage k+1
  logic       out_v_r;
  ctl_t       ctl_r [0:8]; // ctl_r[k] is stage k+2

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[8:0], in_ch.valid};
      out_v_r <= vld_r[9];
    end
  end

  // ---------------- stage 1: beaker test, depth ----------------
  logic signed [32:0] dx, dy, dz, depth_nxt;
  logic               apply_nxt;
  logic               apply1_r, vneg1_r, box1_r;
  logic signed [32:0] depth1_r;
  logic        [30:0] r1_r, hx1_r, hy1_r, hz1_r;
  logic        [31:0] avy1_r;

  always_comb begin
    dx        = {in_ch.pos_x[31], in_ch.pos_x} - {bcx_r[31], bcx_r};
    dy        = {in_ch.pos_y[31], in_ch.pos_y} - {bcy_r[31], bcy_r};
    dz        = {in_ch.pos_z[31], in_ch.pos_z} - {bcz_r[31], bcz_r};
    depth_nxt = {surf_r[31], surf_r} - {in_ch.pos_y[31], in_ch.pos_y};
    apply_nxt = !in_ch.is_static &&
                (in_ch.shape_kind == SHAPE_SPHERE || in_ch.shape_kind == SHAPE_BOX) &&
                in_range(dx, bhalf_r) && in_range(dy, bhalf_r) && in_range(dz, bhalf_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      apply1_r <= apply_nxt;
      vneg1_r  <= in_ch.vel_y[31];
      box1_r   <= in_ch.shape_kind == SHAPE_BOX;
      depth1_r <= depth_nxt;
      r1_r     <= in_ch.sphere_radius;
      hx1_r    <= in_ch.half_x;
      hy1_r    <= in_ch.half_y;
      hz1_r    <= in_ch.half_z;
      avy1_r   <= in_ch.vel_y[31] ? 32'(-in_ch.vel_y) : 32'(in_ch.vel_y);
    end
  end

  // ---------------- stage 2: classify, operand select, |v|*drag ----------------
  logic signed [33:0] dep34, r34, h34, t34, sl34;
  logic        [31:0] lim, s_clamp;
  logic               below, above;
  ctl_t               ctl_nxt;
  logic        [31:0] m1_nxt, m2_nxt, da_nxt, db_nxt;
  logic        [32:0] m3_nxt;
  logic        [62:0] md_full;
  logic        [31:0] m1_2_r, m2_2_r, da2_r, db2_r;
  logic        [32:0] m3_2_r;
  logic        [45:0] md2_r;

  always_comb begin
    dep34 = {depth1_r[32], depth1_r};
    r34   = {3'b000, r1_r};
    below = dep34 <= -r34;
    above = dep34 >= r34;
    h34   = dep34 + r34;
    t34   = (r34 <<< 1) - dep34;            // 3r - h
    sl34  = dep34 + {3'b000, hy1_r};
    lim   = {hy1_r, 1'b0};
    if (sl34[33])                       s_clamp = '0;
    else if (sl34[32:0] > {1'b0, lim})  s_clamp = lim;
    else                                s_clamp = sl34[31:0];

    ctl_nxt.apply = apply1_r;
    ctl_nxt.vneg  = vneg1_r;
    ctl_nxt.rzero = 1'b0;
    ctl_nxt.rone  = 1'b0;
    m1_nxt = h34[31:0];
    m2_nxt = h34[31:0];
    m3_nxt = t34[32:0];
    da_nxt = h34[31:0];
    db_nxt = {1'b0, r1_r};
    if (box1_r) begin
      ctl_nxt.cls   = VC_BOX;
      ctl_nxt.rzero = hx1_r == '0 || hy1_r == '0 || hz1_r == '0;
      m1_nxt = {hx1_r, 1'b0};
      m2_nxt = {hz1_r, 1'b0};
      m3_nxt = {1'b0, s_clamp};
      da_nxt = s_clamp;
      db_nxt = lim;
    end else if (below) begin
      ctl_nxt.cls   = VC_ZERO;
      ctl_nxt.rzero = 1'b1;
      m3_nxt        = '0;
    end else if (above) begin
      ctl_nxt.cls   = VC_FULL;
      ctl_nxt.rzero = r1_r == '0;
      ctl_nxt.rone  = r1_r != '0;
      m1_nxt = {1'b0, r1_r};
      m2_nxt = {1'b0, r1_r};
      m3_nxt = {2'b00, r1_r};
    end else begin
      ctl_nxt.cls = VC_PART;
    end
    md_full = 63'(avy1_r) * 63'(drag_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_nxt;
      m1_2_r   <= m1_nxt;
      m2_2_r   <= m2_nxt;
      m3_2_r   <= m3_nxt;
      da2_r    <= da_nxt;
      db2_r    <= db_nxt;
      md2_r    <= md_full[61:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k < 9; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // ---------------- stage 3: first product, divider bits 16..11 ----------------
  logic [63:0] p_full;
  logic [31:0] rem3_nxt;
  logic [5:0]  xq3_nxt;
  divs_t       ds3;
  logic [47:0] p3_r;
  logic [32:0] m3_3_r;
  logic [31:0] rem3_r, db3_r;
  logic [5:0]  xq3_r;
  logic [45:0] md3_r;

  always_comb begin
    p_full = 64'(m1_2_r) * 64'(m2_2_r);
    xq3_nxt[5] = da2_r >= db2_r;
    rem3_nxt   = xq3_nxt[5] ? da2_r - db2_r : da2_r;
    for (int i = 4; i >= 0; i--) begin
      ds3         = div_step(rem3_nxt, db2_r);
      xq3_nxt[i]  = ds3.qbit;
      rem3_nxt    = ds3.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r   <= p_full[63:16];
      m3_3_r <= m3_2_r;
      rem3_r <= rem3_nxt;
      xq3_r  <= xq3_nxt;
      db3_r  <= db2_r;
      md3_r  <= md2_r;
    end
  end

  // ---------------- stage 4: second product partials, divider ----------------
  logic [31:0] rem4_nxt;
  logic [4:0]  xq4_lo;
  divs_t       ds4;
  logic [56:0] ph4_r, pl4_r;
  logic [31:0] rem4_r, db4_r;
  logic [10:0] xq4_r;
  logic [45:0] md4_r;

  always_comb begin
    rem4_nxt = rem3_r;
    for (int i = 4; i >= 0; i--) begin
      ds4       = div_step(rem4_nxt, db3_r);
      xq4_lo[i] = ds4.qbit;
      rem4_nxt  = ds4.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph4_r  <= 57'(p3_r[47:24]) * 57'(m3_3_r);
      pl4_r  <= 57'(p3_r[23:0]) * 57'(m3_3_r);
      rem4_r <= rem4_nxt;
      xq4_r  <= {xq3_r, xq4_lo};
      db4_r  <= db3_r;
      md4_r  <= md3_r;
    end
  end

  // ---------------- stage 5: second product sum, divider done ----------------
  logic [80:0] sum_b;
  logic [31:0] rem5;
  logic [5:0]  xq5_lo;
  divs_t       ds5;
  logic [63:0] b5_r;
  logic        ovfb5_r;
  logic [16:0] x5_r;
  logic [45:0] md5_r;

  always_comb begin
    sum_b = {ph4_r, 24'b0} + 81'(pl4_r);
    rem5  = rem4_r;
    for (int i = 5; i >= 0; i--) begin
      ds5       = div_step(rem5, db4_r);
      xq5_lo[i] = ds5.qbit;
      rem5      = ds5.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5_r    <= sum_b[79:16];
      ovfb5_r <= sum_b[80];
      x5_r    <= {xq4_r, xq5_lo};
      md5_r   <= md4_r;
    end
  end

  // ---------------- stage 6: divide by three (upper half), x^2 ----------------
  logic [63:0] n6;
  logic [1:0]  r6;
  logic [31:0] qhi_nxt;
  div3_t       d6;
  logic [33:0] xx;
  logic [31:0] qhi6_r, nlo6_r;
  logic [1:0]  rem6_r;
  logic [63:0] b6_r;
  logic        ovfb6_r;
  logic [16:0] x6_r;
  logic [17:0] x2_6_r;
  logic [45:0] md6_r;

  always_comb begin
    // full sphere takes 4/3 of r^3, the cap one third of h^2(3r-h)
    n6 = (ctl_r[3].cls == VC_FULL) ? {b5_r[61:0], 2'b00} : b5_r;
    r6 = '0;
    for (int i = 0; i < 8; i++) begin
      d6 = div3_nib(r6, n6[63-4*i -: 4]);
      qhi_nxt[31-4*i -: 4] = d6.q;
      r6 = d6.rem;
    end
    xx = 34'(x5_r) * 34'(x5_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qhi6_r  <= qhi_nxt;
      rem6_r  <= r6;
      nlo6_r  <= n6[31:0];
      b6_r    <= b5_r;
      ovfb6_r <= ovfb5_r;
      x6_r    <= x5_r;
      x2_6_r  <= xx[33:16];
      md6_r   <= md5_r;
    end
  end

  // ---------------- stage 7: divide by three (lower half), ratio ----------------
  logic [1:0]  r7;
  logic [31:0] qlo_nxt;
  div3_t       d7;
  logic [17:0] fx;
  logic [35:0] cap;
  logic [17:0] ratio_nxt;
  logic [63:0] q7_r, b7_r;
  logic        ovfb7_r;
  logic [17:0] ratio7_r;
  logic [45:0] md7_r;

  always_comb begin
    r7 = rem6_r;
    for (int i = 0; i < 8; i++) begin
      d7 = div3_nib(r7, nlo6_r[31-4*i -: 4]);
      qlo_nxt[31-4*i -: 4] = d7.q;
      r7 = d7.rem;
    end
    // cap ratio x^2 (3 - x) / 4
    fx  = THREE_Q16 - {1'b0, x6_r};
    cap = 36'(x2_6_r) * 36'(fx);
    if (ctl_r[4].rzero)              ratio_nxt = '0;
    else if (ctl_r[4].rone)          ratio_nxt = ONE_Q16;
    else if (ctl_r[4].cls == VC_PART) ratio_nxt = cap[35:18];
    else                             ratio_nxt = {1'b0, x6_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q7_r     <= {qhi6_r, qlo_nxt};
      b7_r     <= b6_r;
      ovfb7_r  <= ovfb6_r;
      ratio7_r <= ratio_nxt;
      md7_r    <= md6_r;
    end
  end

  // ---------------- stage 8: pi partials, damping magnitude ----------------
  logic [63:0] dm_full;
  logic [49:0] qh8_r, ql8_r;
  logic [63:0] b8_r;
  logic        ovfb8_r;
  logic [47:0] dm8_r;

  assign dm_full = 64'(md7_r) * 64'(ratio7_r);

  always_ff @(posedge clk) begin
    if (en) begin
      qh8_r   <= 50'(q7_r[63:32]) * 50'(PI_Q16);
      ql8_r   <= 50'(q7_r[31:0]) * 50'(PI_Q16);
      b8_r    <= b7_r;
      ovfb8_r <= ovfb7_r;
      dm8_r   <= dm_full[63:16];
    end
  end

  // ---------------- stage 9: volume ----------------
  logic [81:0] sum_pi;
  logic [63:0] vol_nxt;
  logic        ovf_nxt;
  logic [63:0] vol9_r;
  logic        ovf9_r;
  logic [47:0] dm9_r;

  always_comb begin
    sum_pi = {qh8_r, 32'b0} + 82'(ql8_r);
    case (ctl_r[6].cls)
      VC_BOX: begin
        vol_nxt = b8_r;
        ovf_nxt = ovfb8_r;
      end
      VC_ZERO: begin
        vol_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
        vol_nxt = sum_pi[79:16];
        ovf_nxt = ovfb8_r || sum_pi[81:80] != 2'b00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vol9_r <= vol_nxt;
      ovf9_r <= ovf_nxt;
      dm9_r  <= dm8_r;
    end
  end

  // ---------------- stage 10: force partials ----------------
  logic [45:0] pphh_r, pphl_r;
  logic [63:0] pplh_r, ppll_r;
  logic        ovf10_r, dgnz10_r;
  logic [47:0] dm10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pphh_r   <= 46'(dg_r[45:32]) * 46'(vol9_r[63:32]);
      pphl_r   <= 46'(dg_r[45:32]) * 46'(vol9_r[31:0]);
      pplh_r   <= 64'(dg_r[31:0]) * 64'(vol9_r[63:32]);
      ppll_r   <= 64'(dg_r[31:0]) * 64'(vol9_r[31:0]);
      ovf10_r  <= ovf9_r;
      dgnz10_r <= dg_r != '0;
      dm10_r   <= dm9_r;
    end
  end

  // ---------------- output register ----------------
  logic [109:0] pf;
  logic         sat_nxt;
  logic [46:0]  force_nxt;
  logic [46:0]  buoy_r;
  logic [47:0]  damp_r;
  logic         applied_r, sat_r;

  always_comb begin
    pf = {pphh_r, 64'b0} + 110'({pphl_r, 32'b0}) + 110'({pplh_r, 32'b0}) + 110'(ppll_r);
    // clip once the Q16 product reaches 2^63 (force above 2^47-1)
    sat_nxt   = dgnz10_r && (ovf10_r || pf[109:63] != '0);
    force_nxt = sat_nxt ? FORCE_MAX : pf[62:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_r[8].apply) begin
        buoy_r    <= force_nxt;
        damp_r    <= ctl_r[8].vneg ? dm10_r : 48'(-dm10_r);
        applied_r <= 1'b1;
        sat_r     <= sat_nxt;
      end else begin
        buoy_r    <= '0;
        damp_r    <= '0;
        applied_r <= 1'b0;
        sat_r     <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.buoyant_force = buoy_r;
  assign out_ch.damping_force = damp_r;
  assign out_ch.force_applied = applied_r;
  assign out_ch.saturated     = sat_r;

endmodule
`default_nettype wire
